[src/pwm_window_scorer_core_macros.svh]
// Assertion macros for the motif window scorer.
// Each use expects clk and arst_n in scope; no other dependencies.
`ifndef PWM_WINDOW_SCORER_CORE_MACROS_SVH
`define PWM_WINDOW_SCORER_CORE_MACROS_SVH

// property that must hold at every edge out of reset
`define PWSC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define PWSC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[src/pwsc_pkg.sv]
// Shared types, constants and the letter decoder of the motif window scorer.
// No dependencies; the module files refer to it by scoped names.
package pwsc_pkg;

	localparam int MAX_MOTIF  = 32;
	localparam int IDX_W      = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;
	localparam int LEN_W      = $clog2(MAX_MOTIF + 1);
	localparam int CFG_W      = 6;
	localparam int CHAR_W     = 8;
	localparam int POS_W      = 5;
	localparam int LET_W      = 2;
	localparam int WEIGHT_W   = 16;
	localparam int SCORE_W    = 21;
	localparam int INDEX_W    = 32;
	localparam int LETTERS    = 4;
	localparam int SUM_W      = ((WEIGHT_W + LEN_W + 1) > (SCORE_W + 1)) ?
	                            (WEIGHT_W + LEN_W + 1) : (SCORE_W + 1);
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 56;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [CFG_W-1:0] MOTIF_LEN_RESET = CFG_W'(8);

	localparam logic signed [SUM_W-1:0] SCORE_MAX = SUM_W'((64'sd1 <<< (SCORE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SCORE_MIN = -SUM_W'(64'sd1 <<< (SCORE_W - 1));

	localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UC = 8'h43;
	localparam logic [CHAR_W-1:0] CH_LC = 8'h63;
	localparam logic [CHAR_W-1:0] CH_UG = 8'h47;
	localparam logic [CHAR_W-1:0] CH_LG = 8'h67;
	localparam logic [CHAR_W-1:0] CH_UT = 8'h54;
	localparam logic [CHAR_W-1:0] CH_LT = 8'h74;

	typedef enum logic [2:0] {
		LET_A, LET_C, LET_G, LET_T, LET_OTHER
	} letter_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_CHAR = 1'b1
	} cmd_t;

	typedef enum logic {
		ENT_LOAD,
		ENT_SCORE
	} entry_kind_t;

	// one queue word: either a weight write or an aligned window to score
	typedef struct packed {
		entry_kind_t                   kind;
		letter_t [MAX_MOTIF-1:0]       letters;   // lane i pairs with matrix row i
		logic [INDEX_W-1:0]            start;
		logic [POS_W-1:0]              wpos;
		logic [LET_W-1:0]              wlet;
		logic [WEIGHT_W-1:0]           wval;
	} q_entry_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_status_t;

	function automatic letter_t letter_code(input logic [CHAR_W-1:0] ch);
		letter_t code;
		case (ch)
			CH_UA, CH_LA: code = LET_A;
			CH_UC, CH_LC: code = LET_C;
			CH_UG, CH_LG: code = LET_G;
			CH_UT, CH_LT: code = LET_T;
			default:      code = LET_OTHER;
		endcase
		return code;
	endfunction

endpackage

[src/pwsc_front.sv]
// Front end of the motif window scorer: decodes characters, keeps the letter
// history and counters, and builds aligned queue words. Uses pwsc_pkg.
module pwsc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [pwsc_pkg::CFG_W-1:0]     motif_length,
	input  logic                           accept,
	input  pwsc_pkg::cmd_t                 cmd,
	input  logic                           first,
	input  logic [pwsc_pkg::CHAR_W-1:0]    base_char,
	input  logic [pwsc_pkg::POS_W-1:0]     weight_position,
	input  logic [pwsc_pkg::LET_W-1:0]     weight_letter,
	input  logic [pwsc_pkg::WEIGHT_W-1:0]  weight_value,
	output logic                           push,
	output pwsc_pkg::q_entry_t             entry
);

	pwsc_pkg::letter_t               hist_q [pwsc_pkg::MAX_MOTIF];
	pwsc_pkg::letter_t               hist_n [pwsc_pkg::MAX_MOTIF];
	logic [pwsc_pkg::INDEX_W-1:0]    chars_q, chars_n;
	logic [pwsc_pkg::LEN_W-1:0]      fill_q, fill_n, fill_base;
	logic [pwsc_pkg::LEN_W-1:0]      eff_len;
	logic [pwsc_pkg::IDX_W-1:0]      len_m1;
	logic [pwsc_pkg::IDX_W-1:0]      sel [pwsc_pkg::MAX_MOTIF];
	logic                            is_char;
	logic                            hit;

	always_comb begin
		if (motif_length == '0) begin
			eff_len = pwsc_pkg::LEN_W'(1);
		end else if (int'(motif_length) > pwsc_pkg::MAX_MOTIF) begin
			eff_len = pwsc_pkg::LEN_W'(pwsc_pkg::MAX_MOTIF);
		end else begin
			eff_len = pwsc_pkg::LEN_W'(motif_length);
		end
		len_m1 = pwsc_pkg::IDX_W'(eff_len - pwsc_pkg::LEN_W'(1));
	end

	// history after this character: newest in entry 0, cleared on a new sequence
	always_comb begin
		hist_n[0] = pwsc_pkg::letter_code(base_char);
		for (int k = 1; k < pwsc_pkg::MAX_MOTIF; k++) begin
			hist_n[k] = first ? pwsc_pkg::LET_OTHER : hist_q[k-1];
		end
		chars_n   = (first ? '0 : chars_q) + pwsc_pkg::INDEX_W'(1);
		fill_base = first ? '0 : fill_q;
		fill_n    = (int'(fill_base) < pwsc_pkg::MAX_MOTIF) ?
		            fill_base + pwsc_pkg::LEN_W'(1) : fill_base;
		hit       = (fill_n >= eff_len);
	end

	// align the window: oldest letter of the window goes to matrix row 0
	always_comb begin
		entry.kind  = (cmd == pwsc_pkg::CMD_LOAD) ? pwsc_pkg::ENT_LOAD : pwsc_pkg::ENT_SCORE;
		entry.start = chars_n - pwsc_pkg::INDEX_W'(eff_len);
		entry.wpos  = weight_position;
		entry.wlet  = weight_letter;
		entry.wval  = weight_value;
		for (int i = 0; i < pwsc_pkg::MAX_MOTIF; i++) begin
			sel[i] = len_m1 - pwsc_pkg::IDX_W'(i);
			if (pwsc_pkg::LEN_W'(i) < eff_len) begin
				entry.letters[i] = hist_n[sel[i]];
			end else begin
				entry.letters[i] = pwsc_pkg::LET_OTHER;
			end
		end
	end

	assign is_char = accept && (cmd == pwsc_pkg::CMD_CHAR);
	// drop characters that complete no window
	assign push    = accept && ((cmd == pwsc_pkg::CMD_LOAD) || hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < pwsc_pkg::MAX_MOTIF; k++) begin
				hist_q[k] <= pwsc_pkg::LET_OTHER;
			end
			chars_q <= '0;
			fill_q  <= '0;
		end else if (is_char) begin
			for (int k = 0; k < pwsc_pkg::MAX_MOTIF; k++) begin
				hist_q[k] <= hist_n[k];
			end
			chars_q <= chars_n;
			fill_q  <= fill_n;
		end
	end

endmodule

[src/pwsc_queue.sv]
// Short word queue between front and back of the motif window scorer.
// Uses pwsc_pkg for the word and status types.
module pwsc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pwsc_pkg::q_entry_t    push_data,
	input  logic                  pop,
	output pwsc_pkg::q_entry_t    head,
	output pwsc_pkg::q_status_t   status
);

	pwsc_pkg::q_entry_t            mem_q [pwsc_pkg::QDEPTH];
	logic [pwsc_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [pwsc_pkg::QCNT_W-1:0]   count_q;
	logic                          do_push, do_pop;

	assign status.count = count_q;
	assign status.full  = (int'(count_q) == pwsc_pkg::QDEPTH);
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + pwsc_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + pwsc_pkg::QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + pwsc_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - pwsc_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/pwsc_back.sv]
// Back end of the motif window scorer: holds the weight matrix, applies loads
// and sums aligned windows through a registered adder tree. Uses pwsc_pkg.
module pwsc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pwsc_pkg::q_entry_t             head,
	input  pwsc_pkg::q_status_t            qstat,
	output logic                           pop,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [pwsc_pkg::SCORE_W-1:0]   out_score,
	output logic [pwsc_pkg::INDEX_W-1:0]   out_start
);

	localparam int G1 = (pwsc_pkg::MAX_MOTIF + 3) / 4;
	localparam int G2 = (G1 + 3) / 4;

	logic [pwsc_pkg::LETTERS-1:0][pwsc_pkg::WEIGHT_W-1:0] wtab_q [pwsc_pkg::MAX_MOTIF];

	logic                                  en;
	logic                                  is_load;
	logic                                  valid_s1, valid_s2, valid_s3, out_valid_q;
	logic signed [pwsc_pkg::WEIGHT_W-1:0]  w_s1 [pwsc_pkg::MAX_MOTIF];
	logic signed [pwsc_pkg::WEIGHT_W-1:0]  w_sel [pwsc_pkg::MAX_MOTIF];
	logic [pwsc_pkg::INDEX_W-1:0]          start_s1, start_s2, start_s3, out_start_q;
	logic signed [pwsc_pkg::SUM_W-1:0]     p1 [G1];
	logic signed [pwsc_pkg::SUM_W-1:0]     sum_s2 [G1];
	logic signed [pwsc_pkg::SUM_W-1:0]     p2 [G2];
	logic signed [pwsc_pkg::SUM_W-1:0]     sum_s3 [G2];
	logic signed [pwsc_pkg::SUM_W-1:0]     total;
	logic signed [pwsc_pkg::SUM_W-1:0]     sat;
	logic [pwsc_pkg::SCORE_W-1:0]          out_score_q;

	// advance the whole back end unless a result waits at the output
	assign en      = !out_valid_q || out_ready;
	assign pop     = en && !qstat.empty;
	assign is_load = (head.kind == pwsc_pkg::ENT_LOAD);

	// per-lane weight lookup; an unknown letter adds zero
	always_comb begin
		for (int i = 0; i < pwsc_pkg::MAX_MOTIF; i++) begin
			if (head.letters[i] == pwsc_pkg::LET_OTHER) begin
				w_sel[i] = '0;
			end else begin
				w_sel[i] = wtab_q[i][pwsc_pkg::LET_W'(head.letters[i])];
			end
		end
	end

	always_comb begin
		for (int g = 0; g < G1; g++) begin
			p1[g] = '0;
			for (int k = 0; k < 4; k++) begin
				if (4 * g + k < pwsc_pkg::MAX_MOTIF) begin
					p1[g] = p1[g] + pwsc_pkg::SUM_W'(w_s1[4 * g + k]);
				end
			end
		end
		for (int g = 0; g < G2; g++) begin
			p2[g] = '0;
			for (int k = 0; k < 4; k++) begin
				if (4 * g + k < G1) begin
					p2[g] = p2[g] + sum_s2[4 * g + k];
				end
			end
		end
		total = '0;
		for (int g = 0; g < G2; g++) begin
			total = total + sum_s3[g];
		end
		if (total > pwsc_pkg::SCORE_MAX) begin
			sat = pwsc_pkg::SCORE_MAX;
		end else if (total < pwsc_pkg::SCORE_MIN) begin
			sat = pwsc_pkg::SCORE_MIN;
		end else begin
			sat = total;
		end
	end

	// weight matrix: rows out of range are never matched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < pwsc_pkg::MAX_MOTIF; r++) begin
				wtab_q[r] <= '0;
			end
		end else if (pop && is_load) begin
			for (int r = 0; r < pwsc_pkg::MAX_MOTIF; r++) begin
				if (int'(head.wpos) == r) begin
					wtab_q[r][head.wlet] <= head.wval;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < pwsc_pkg::MAX_MOTIF; i++) begin
				w_s1[i] <= w_sel[i];
			end
			start_s1 <= head.start;
			for (int g = 0; g < G1; g++) begin
				sum_s2[g] <= p1[g];
			end
			start_s2 <= start_s1;
			for (int g = 0; g < G2; g++) begin
				sum_s3[g] <= p2[g];
			end
			start_s3    <= start_s2;
			out_score_q <= pwsc_pkg::SCORE_W'(sat);
			out_start_q <= start_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop && !is_load;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_score = out_score_q;
	assign out_start = out_start_q;

endmodule

[src/pwm_window_scorer_core.sv]
// Top level of the motif window scorer: stream ports, window length register,
// front end, word queue and back end. Uses pwsc_pkg and the assertion macros.
//
// Position weight matrix scanner. Feed DNA characters one per word; once a
// window of motif_length bases has been seen since the start of the sequence
// (a word with first set), every character returns one result: the signed
// Q13.8 sum of weight[row][letter] over the window and the index of the
// window's first character. A, C, G, T in either case score; any other byte
// adds zero. Weights are written one at a time by load words (cmd low), which
// take effect in stream order, so a load is seen by every later character.
// The block takes one word per clock while the queue has room. With the output
// ready, an accepted character passes through the queue, the weight lookup
// register, two adder-tree stages and the output register. The four-word
// queue between the front and back halves absorbs output stalls; once it
// fills, s_axis_tready drops until the output drains. Windows of up to 32
// bases are supported; a length of zero acts as one and a larger value as
// 32. Change the window length only while idle. No clearing pass: the weight
// matrix resets to zero at once.
`include "pwm_window_scorer_core_macros.svh"

module pwm_window_scorer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration: window length
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pwsc_pkg::CFG_W-1:0]           cfg_data,
	// input words
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// base_char [7:0], weight_position [12:8], weight_letter [14:13],
	// weight_value [30:15], zero [31]
	input  logic [pwsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// cmd [0], first [1]
	input  logic [pwsc_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	// results
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// window_score [20:0], window_start [52:21], zero [55:53]
	output logic [pwsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	logic [pwsc_pkg::CFG_W-1:0]     motif_len_q;
	logic                           in_accept;
	logic                           push;
	logic                           pop;
	pwsc_pkg::q_entry_t             push_data;
	pwsc_pkg::q_entry_t             head;
	pwsc_pkg::q_status_t            qstat;
	logic [pwsc_pkg::SCORE_W-1:0]   score;
	logic [pwsc_pkg::INDEX_W-1:0]   start;

	// the register is always writable; the user must write it only while idle, the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_len_q <= pwsc_pkg::MOTIF_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			motif_len_q <= cfg_data;
		end
	end

	// hold off the source only when the queue has no room
	assign s_axis_tready = !qstat.full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	pwsc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.motif_length    (motif_len_q),
		.accept          (in_accept),
		.cmd             (pwsc_pkg::cmd_t'(s_axis_tuser[0])),
		.first           (s_axis_tuser[1]),
		.base_char       (s_axis_tdata[7:0]),
		.weight_position (s_axis_tdata[12:8]),
		.weight_letter   (s_axis_tdata[14:13]),
		.weight_value    (s_axis_tdata[30:15]),
		.push            (push),
		.entry           (push_data)
	);

	pwsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (qstat)
	);

	pwsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_score (score),
		.out_start (start)
	);

	// pack the result word, score in the low bits
	assign m_axis_tdata = {
		{(pwsc_pkg::OUT_TDATA_W - pwsc_pkg::SCORE_W - pwsc_pkg::INDEX_W){1'b0}},
		start,
		score
	};

	// queue occupancy stays within its depth
	`PWSC_ASSERT_ALWAYS(a_q_bound, int'(qstat.count) <= pwsc_pkg::QDEPTH, "queue overfilled")
	// occupancy moves by at most one word per cycle
	`PWSC_ASSERT_ALWAYS(a_q_step, (qstat.count == $past(qstat.count)) || (qstat.count == $past(qstat.count) + 1'b1) || ($past(qstat.count) == qstat.count + 1'b1), "queue count jumped")
	// a full queue must stall the source
	`PWSC_ASSERT_IMPLY(a_full_stall, qstat.full, !s_axis_tready, "accepting into a full queue")

endmodule
